// ===== rtl/swm_pkg.sv =====
// swm_pkg: shared types and constants for the sliding window median filter.
// Used by swm_cell, swm_median and sliding_window_median; no dependencies.
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = SAMPLE_W + 1;
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;

  // per-cycle command broadcast to every cell of the sorted row
  typedef struct packed {
    logic    step;    // insert a sample, age kept entries
    logic    purge;   // squeeze out one stale entry, no insert
    logic    clear;   // end of sequence: drop every entry after the insert
    sample_t sample;  // sample being inserted
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// swm_cell: one slot of the sorted window row (value, age, valid).
// Handles removal of one entry and sorted insertion together with its neighbors.
// Depends on swm_pkg.
`default_nettype none

module swm_cell #(
  parameter int AW = 6,
  parameter int KW = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire swm_pkg::ctrl_t   ctrl,
  input  wire logic [KW-1:0]    km1,
  input  wire logic             shl,
  // raw contents of the right neighbor
  input  wire logic             r_valid,
  input  wire swm_pkg::sample_t r_val,
  input  wire logic [AW-1:0]    r_age,
  input  wire logic             r_gt,
  // left neighbor after removal
  input  wire logic             l_a_valid,
  input  wire swm_pkg::sample_t l_a_val,
  input  wire logic [AW-1:0]    l_a_age,
  input  wire logic             l_a_gt,
  // own raw contents
  output logic                  valid,
  output swm_pkg::sample_t      val,
  output logic [AW-1:0]         age,
  output logic                  gt,
  output logic                  cand,
  // own contents after removal
  output logic                  a_valid,
  output swm_pkg::sample_t      a_val,
  output logic [AW-1:0]         a_age,
  output logic                  a_gt
);
  import swm_pkg::*;

  logic          valid_r, valid_nxt;
  sample_t       val_r, val_nxt;
  logic [AW-1:0] age_r, age_nxt;

  assign valid = valid_r;
  assign val   = val_r;
  assign age   = age_r;
  assign gt    = valid_r && (val_r > ctrl.sample);
  assign cand  = valid_r && ({{(KW-AW){1'b0}}, age_r} >= km1);

  // removal: cells at or above the removed slot take their right neighbor
  assign a_valid = shl ? r_valid : valid_r;
  assign a_val   = shl ? r_val   : val_r;
  assign a_age   = shl ? r_age   : age_r;
  assign a_gt    = shl ? r_gt    : gt;

  always_comb begin
    valid_nxt = valid_r;
    val_nxt   = val_r;
    age_nxt   = age_r;
    if (ctrl.step) begin
      if (l_a_gt) begin
        valid_nxt = 1'b1;
        val_nxt   = l_a_val;
        age_nxt   = l_a_age + AW'(1);
      end else if (a_valid && !a_gt) begin
        valid_nxt = 1'b1;
        val_nxt   = a_val;
        age_nxt   = a_age + AW'(1);
      end else if (l_a_valid) begin
        // first slot past every entry not above the sample
        valid_nxt = 1'b1;
        val_nxt   = ctrl.sample;
        age_nxt   = '0;
      end else begin
        valid_nxt = 1'b0;
      end
      if (ctrl.clear) begin
        valid_nxt = 1'b0;
      end
    end else if (ctrl.purge) begin
      valid_nxt = a_valid;
      val_nxt   = a_val;
      age_nxt   = a_age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    age_r <= age_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/swm_median.sv =====
// swm_median: picks the two middle entries of the sorted row and adds them.
// Selection is an and-or over the cells; depends on swm_pkg.
`default_nettype none

module swm_median #(
  parameter int MAX_WINDOW = 64,
  parameter int KW         = 7
) (
  input  wire swm_pkg::sample_t vals [MAX_WINDOW],
  input  wire logic [KW-1:0]    k,
  output swm_pkg::median_t      median_x2
);
  import swm_pkg::*;

  logic [KW-1:0] lo_idx;
  logic [KW-1:0] hi_idx;
  logic [SAMPLE_W-1:0] lo_bits;
  logic [SAMPLE_W-1:0] hi_bits;

  // odd window: both point at the middle; even: the two middle entries
  assign lo_idx = (k - KW'(1)) >> 1;
  assign hi_idx = k >> 1;

  always_comb begin
    lo_bits = '0;
    hi_bits = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      lo_bits = lo_bits | (vals[i] & {SAMPLE_W{32'(lo_idx) == i}});
      hi_bits = hi_bits | (vals[i] & {SAMPLE_W{32'(hi_idx) == i}});
    end
  end

  assign median_x2 = MEDIAN_W'(signed'(lo_bits)) + MEDIAN_W'(signed'(hi_bits));

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median.sv =====
// Sliding window median filter: keeps the last window_size signed samples in a
// row of MAX_WINDOW sorted cells and, once the window is full, returns twice the
// median (sum of the two middle entries) for every sample. One sample is taken
// per clock while no excess entries are being purged and the output is not
// stalled; each passes through the cell row and then the output register,
// which waits for out_ready. A last_sample transfer empties the window after
// its own result. Shrinking window_size leaves excess old entries in the row;
// before the next sample is taken they are squeezed out one per cycle while no
// result is pending. window_size is taken as 1 when zero and as MAX_WINDOW
// when larger. Depends on swm_pkg, swm_cell and swm_median.
`default_nettype none

module sliding_window_median #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [swm_pkg::CFG_W-1:0]     cfg_window_size,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [swm_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                          in_last_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [swm_pkg::MEDIAN_W-1:0] out_median_x2,
  output logic                               out_last_median
);
  import swm_pkg::*;

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KW = $clog2(MAX_WINDOW + 1);

  logic [CFG_W-1:0] window_r;
  logic [KW-1:0]    k;
  logic [KW-1:0]    km1;
  logic [KW-1:0]    fill_r, fill_nxt, fill_after;

  logic pend_r, pend_nxt, pend_last_r, pend_last_nxt;
  logic out_valid_r, out_valid_nxt;
  median_t out_median_r;
  logic    out_last_r;
  logic    pend_adv;

  ctrl_t ctrl;
  logic  accept;
  logic  multi;
  logic  emit;

  logic [MAX_WINDOW-1:0] cand_vec;
  logic [MAX_WINDOW-1:0] del_oh;
  logic [MAX_WINDOW-1:0] shl_vec;
  logic [MAX_WINDOW-1:0] valid_vec;

  logic          c_valid [MAX_WINDOW];
  sample_t       c_val   [MAX_WINDOW];
  logic [AW-1:0] c_age   [MAX_WINDOW];
  logic          c_gt    [MAX_WINDOW];
  logic          c_a_valid [MAX_WINDOW];
  sample_t       c_a_val   [MAX_WINDOW];
  logic [AW-1:0] c_a_age   [MAX_WINDOW];
  logic          c_a_gt    [MAX_WINDOW];

  median_t med_sum;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_r <= cfg_window_size;
    end
  end

  always_comb begin
    if (window_r == '0) begin
      k = KW'(1);
    end else if (32'(window_r) > MAX_WINDOW) begin
      k = KW'(MAX_WINDOW);
    end else begin
      k = KW'(window_r);
    end
  end
  assign km1 = k - KW'(1);

  // ---------------------------------------------------------------- removal
  // lowest stale entry is removed; everything at or above it shifts down
  assign del_oh  = cand_vec & (~cand_vec + MAX_WINDOW'(1));
  assign shl_vec = ~(del_oh - MAX_WINDOW'(1));
  assign multi   = |(cand_vec & (cand_vec - MAX_WINDOW'(1)));

  // ---------------------------------------------------------------- control
  assign pend_adv = !out_valid_r || out_ready;
  assign in_ready = !multi && (!pend_r || pend_adv);
  assign accept   = in_valid && in_ready;

  assign ctrl.step   = accept;
  assign ctrl.purge  = multi && !pend_r;
  assign ctrl.clear  = in_last_sample;
  assign ctrl.sample = in_sample;

  assign fill_after = fill_r - KW'(|cand_vec) + KW'(1);
  assign emit       = fill_after == k;

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      fill_nxt = in_last_sample ? '0 : fill_after;
    end else if (ctrl.purge) begin
      fill_nxt = fill_r - KW'(1);
    end
  end

  always_comb begin
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    if (accept && emit) begin
      pend_nxt      = 1'b1;
      pend_last_nxt = in_last_sample;
    end else if (pend_adv) begin
      pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (pend_r && pend_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_last_r <= pend_last_nxt;
    if (pend_r && pend_adv) begin
      out_median_r <= med_sum;
      out_last_r   <= pend_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_median_x2   = out_median_r;
  assign out_last_median = out_last_r;

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic          r_valid, r_gt, l_a_valid, l_a_gt;
    sample_t       r_val, l_a_val;
    logic [AW-1:0] r_age, l_a_age;

    if (i == MAX_WINDOW - 1) begin : g_right_end
      assign r_valid = 1'b0;
      assign r_val   = '0;
      assign r_age   = '0;
      assign r_gt    = 1'b0;
    end else begin : g_right
      assign r_valid = c_valid[i+1];
      assign r_val   = c_val[i+1];
      assign r_age   = c_age[i+1];
      assign r_gt    = c_gt[i+1];
    end

    if (i == 0) begin : g_left_end
      // the bottom slot may always take the sample
      assign l_a_valid = 1'b1;
      assign l_a_val   = '0;
      assign l_a_age   = '0;
      assign l_a_gt    = 1'b0;
    end else begin : g_left
      assign l_a_valid = c_a_valid[i-1];
      assign l_a_val   = c_a_val[i-1];
      assign l_a_age   = c_a_age[i-1];
      assign l_a_gt    = c_a_gt[i-1];
    end

    swm_cell #(
      .AW (AW),
      .KW (KW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .km1       (km1),
      .shl       (shl_vec[i]),
      .r_valid   (r_valid),
      .r_val     (r_val),
      .r_age     (r_age),
      .r_gt      (r_gt),
      .l_a_valid (l_a_valid),
      .l_a_val   (l_a_val),
      .l_a_age   (l_a_age),
      .l_a_gt    (l_a_gt),
      .valid     (c_valid[i]),
      .val       (c_val[i]),
      .age       (c_age[i]),
      .gt        (c_gt[i]),
      .cand      (cand_vec[i]),
      .a_valid   (c_a_valid[i]),
      .a_val     (c_a_val[i]),
      .a_age     (c_a_age[i]),
      .a_gt      (c_a_gt[i])
    );

    assign valid_vec[i] = c_valid[i];
  end

  swm_median #(
    .MAX_WINDOW (MAX_WINDOW),
    .KW         (KW)
  ) u_median (
    .vals      (c_val),
    .k         (k),
    .median_x2 (med_sum)
  );

  // ---------------------------------------------------------------- checks
  logic [MAX_WINDOW-1:0] order_ok;
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_order
    if (i == 0) begin : g_first
      assign order_ok[i] = 1'b1;
    end else begin : g_rest
      assign order_ok[i] = !c_valid[i] || (c_val[i-1] <= c_val[i]);
    end
  end

  a_fill_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) == $countones(valid_vec))
    else $error("fill count disagrees with occupied cells");

  a_packed_low: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + MAX_WINDOW'(1))) == '0)
    else $error("occupied cells are not packed at the bottom");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    &order_ok)
    else $error("cell row out of order");

  a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit |=> pend_r)
    else $error("full window transfer did not queue a result");

endmodule

`default_nettype wire
